FILE: design/assert_macros.svh
// Assertion macros for the checker file of this project.
// Depends on nothing; included by the checker module file only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold at every rising edge once reset is released.
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked with the non-overlapping operator |=>.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: design/kmst_pkg.sv
// Package for the Kruskal spanning tree unit: field widths, sequencer state type.
// Depends on nothing; imported by every module of the unit.
`default_nettype none
package kmst_pkg;
  localparam int VTX_BITS   = 5;
  localparam int WIN_BITS   = 16;
  localparam int TOTAL_BITS = 21;
  localparam int RANK_BITS  = 3;
  localparam logic [RANK_BITS-1:0] RANK_MAX = 3'd7;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 21'h1FFFFF;

  typedef enum logic [11:0] {
    ST_LOAD   = 12'b000000000001,
    ST_SORT_I = 12'b000000000010,
    ST_SORT_R = 12'b000000000100,
    ST_SORT_C = 12'b000000001000,
    ST_INIT   = 12'b000000010000,
    ST_EDGE   = 12'b000000100000,
    ST_EREAD  = 12'b000001000000,
    ST_FIND   = 12'b000010000000,
    ST_COMP   = 12'b000100000000,
    ST_JOIN   = 12'b001000000000,
    ST_OUT    = 12'b010000000000,
    ST_TOTAL  = 12'b100000000000
  } state_t;
endpackage
`default_nettype wire

FILE: design/kmst_edge_ram.sv
// Edge store of the spanning tree unit: one write port, one registered read port.
// Depends on kmst_pkg for nothing but house style; plain generic memory.
`default_nettype none
module kmst_edge_ram
  import kmst_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 26
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: design/kruskal_minimum_spanning_tree_unit.sv
// Top level of the Kruskal spanning tree unit: edge loading, insertion sort,
// union-find sequencer. Depends on kmst_pkg and kmst_edge_ram.
`default_nettype none
// Channel | Direction | Payload
// in_*    | slave     | tdata {edge_weight, vertex_b, vertex_a}, tlast = last_edge
// out_*   | master    | tdata {total_cost, tree_weight, tree_vertex_b, tree_vertex_a},
//         |           | tlast = tuser = is_total
// Edges load at one per cycle while no result is pending. After the last edge the sequencer
// runs an insertion sort through the edge store (index, read and compare states, one shift
// per compare), then two union-find walks per edge, one per endpoint, one parent read per
// cycle, each followed by a second pass over its path to compress it.
// Reset is synchronous, active low, and clears control state only.
// A stalled output holds its item; the sequencer waits when it has the next item ready.
module kruskal_minimum_spanning_tree_unit
  import kmst_pkg::*;
#(
  parameter int VERTICES    = 32,
  parameter int MAX_EDGES   = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // vertex_a[4:0], vertex_b[9:5], edge_weight[25:10]
  input  wire logic        in_tlast,   // last_edge
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // tree_vertex_a, tree_vertex_b, tree_weight, total_cost
  output logic             out_tlast,  // is_total
  output logic             out_tuser   // is_total
);
  // Only the low 16 weight bits travel on the input; vertices beyond 5 bits never arrive.
  localparam int WB = (WEIGHT_BITS < WIN_BITS) ? WEIGHT_BITS : WIN_BITS;
  localparam int NV = (VERTICES < (1 << VTX_BITS)) ? VERTICES : (1 << VTX_BITS);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int EW = 2 * VTX_BITS + WB;
  localparam int KW = EW;
  localparam int PW = $clog2(NV);
  localparam logic [VTX_BITS:0] VLIM = (VTX_BITS + 1)'(VERTICES);

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;       // sort: outer index; run: edge index
  logic [CW-1:0] j_r;
  logic [EW-1:0] cur_r;       // edge being inserted or examined
  logic [PW-1:0] parent_r [NV];
  logic [RANK_BITS-1:0] rank_r [NV];
  logic [TOTAL_BITS-1:0] sum_r;
  logic [VTX_BITS-1:0] walk_r, ra_r;
  logic            side_r;    // 0 finding a, 1 finding b
  logic [PW-1:0]   init_r;
  logic            ovalid_r;
  logic [47:0]     odata_r;
  logic            olast_r;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [EW-1:0]   wdata, rdata;

  // Sort key {weight, a, b}: stored word is {w, b, a}, reordered here.
  function automatic logic [KW-1:0] key(input logic [EW-1:0] e);
    return {e[EW-1:2*VTX_BITS], e[VTX_BITS-1:0], e[2*VTX_BITS-1:VTX_BITS]};
  endfunction

  kmst_edge_ram #(.DEPTH(MAX_EDGES), .WIDTH(EW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [VTX_BITS-1:0] ea, eb;
  logic [VTX_BITS-1:0] pw;
  logic                e_skip;
  assign ea = cur_r[VTX_BITS-1:0];
  assign eb = cur_r[2*VTX_BITS-1:VTX_BITS];
  assign pw = VTX_BITS'(parent_r[walk_r[PW-1:0]]);
  // An edge with an endpoint outside the vertex range is passed over.
  assign e_skip = ({1'b0, rdata[VTX_BITS-1:0]} >= VLIM) ||
                  ({1'b0, rdata[2*VTX_BITS-1:VTX_BITS]} >= VLIM);

  assign in_tready  = (state_r == ST_LOAD) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = olast_r;

  always_comb begin
    we = 1'b0;
    waddr = count_r[AW-1:0];
    wdata = {in_tdata[10+WB-1:10], in_tdata[9:0]};
    raddr = idx_r[AW-1:0];
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_tvalid && in_tready) begin
          we = (count_r < CW'(MAX_EDGES));
          if (in_tlast) begin
            state_nxt = ST_SORT_I;
          end
        end
      end
      ST_SORT_I: begin
        raddr = idx_r[AW-1:0];
        state_nxt = (idx_r >= count_r) ? ST_INIT : ST_SORT_R;
      end
      ST_SORT_R: begin
        raddr = AW'(j_r - 1'b1);
        state_nxt = ST_SORT_C;
      end
      ST_SORT_C: begin
        we = 1'b1;
        if (j_r != '0 && key(rdata) > key(cur_r)) begin
          waddr = j_r[AW-1:0];
          wdata = rdata;
          raddr = AW'(j_r - 2'd2);
          state_nxt = ST_SORT_C;
        end else begin
          waddr = j_r[AW-1:0];
          wdata = cur_r;
          raddr = AW'(idx_r + 1'b1);
          state_nxt = ST_SORT_I;
        end
      end
      ST_INIT: begin
        if (init_r == PW'(NV - 1)) begin
          state_nxt = ST_EDGE;
        end
      end
      ST_EDGE: begin
        raddr = idx_r[AW-1:0];
        state_nxt = (idx_r >= count_r) ? ST_TOTAL : ST_EREAD;
      end
      ST_EREAD: begin
        state_nxt = e_skip ? ST_EDGE : ST_FIND;
      end
      ST_FIND: begin
        if (pw == walk_r) begin
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        if (walk_r == ra_r || pw == ra_r) begin
          state_nxt = side_r ? ST_JOIN : ST_FIND;
        end
      end
      ST_JOIN: begin
        state_nxt = (ra_r == walk_r) ? ST_EDGE : ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_r) begin
          state_nxt = ST_EDGE;
        end
      end
      ST_TOTAL: begin
        if (!ovalid_r) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  logic [VTX_BITS-1:0] root_a;
  // ST_FIND loads ra_r with the root it reaches and restarts walk_r at the endpoint; in ST_COMP ra_r holds the root.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      count_r  <= '0;
      ovalid_r <= 1'b0;
      olast_r  <= 1'b0;
      sum_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (ovalid_r && out_tready) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        ST_LOAD: begin
          if (in_tvalid && in_tready) begin
            if (count_r < CW'(MAX_EDGES)) begin
              count_r <= count_r + 1'b1;
            end
            idx_r  <= CW'(1);
            init_r <= '0;
          end
        end
        ST_SORT_I: begin
          j_r <= idx_r;
        end
        ST_SORT_R: begin
          cur_r <= rdata;
        end
        ST_SORT_C: begin
          if (j_r != '0 && key(rdata) > key(cur_r)) begin
            j_r <= j_r - 1'b1;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_INIT: begin
          parent_r[init_r] <= init_r;
          rank_r[init_r]   <= '0;
          init_r <= init_r + 1'b1;
          idx_r  <= '0;
          sum_r  <= '0;
        end
        ST_EDGE: begin
          idx_r <= idx_r + 1'b1;
        end
        ST_EREAD: begin
          cur_r  <= rdata;
          walk_r <= rdata[VTX_BITS-1:0];
          side_r <= 1'b0;
        end
        ST_FIND: begin
          if (pw == walk_r) begin
            ra_r   <= walk_r;
            walk_r <= side_r ? eb : ea;
          end else begin
            walk_r <= pw;
          end
        end
        ST_COMP: begin
          if (walk_r == ra_r || pw == ra_r) begin
            if (!side_r) begin
              side_r <= 1'b1;
              walk_r <= eb;
              root_a <= ra_r;
            end else begin
              walk_r <= root_a;
            end
          end else begin
            parent_r[walk_r[PW-1:0]] <= ra_r[PW-1:0];
            walk_r <= pw;
          end
        end
        ST_JOIN: begin
          // walk_r = root of a, ra_r = root of b
          if (ra_r != walk_r) begin
            if (rank_r[walk_r[PW-1:0]] > rank_r[ra_r[PW-1:0]]) begin
              parent_r[ra_r[PW-1:0]] <= walk_r[PW-1:0];
            end else begin
              parent_r[walk_r[PW-1:0]] <= ra_r[PW-1:0];
              if (rank_r[walk_r[PW-1:0]] == rank_r[ra_r[PW-1:0]] &&
                  rank_r[ra_r[PW-1:0]] < RANK_MAX) begin
                rank_r[ra_r[PW-1:0]] <= rank_r[ra_r[PW-1:0]] + 1'b1;
              end
            end
            if ({1'b0, sum_r} + TOTAL_BITS'(cur_r[EW-1:2*VTX_BITS]) > {1'b0, TOTAL_MAX}) begin
              sum_r <= TOTAL_MAX;
            end else begin
              sum_r <= sum_r + TOTAL_BITS'(cur_r[EW-1:2*VTX_BITS]);
            end
          end
        end
        ST_OUT: begin
          if (!ovalid_r) begin
            ovalid_r <= 1'b1;
            olast_r  <= 1'b0;
            odata_r  <= {1'b0, TOTAL_BITS'(0), WIN_BITS'(cur_r[EW-1:2*VTX_BITS]), eb, ea};
          end
        end
        ST_TOTAL: begin
          if (!ovalid_r) begin
            ovalid_r <= 1'b1;
            olast_r  <= 1'b1;
            odata_r  <= {1'b0, sum_r, WIN_BITS'(0), VTX_BITS'(0), VTX_BITS'(0)};
            count_r  <= '0;
            sum_r    <= '0;
          end
        end
        default: ;
      endcase
    end
  end
  logic unused_ok;
  assign unused_ok = ^{in_tdata[31:10+WB]};
endmodule
`default_nettype wire

FILE: design/kmst_checker.sv
// Port-level checker for the Kruskal spanning tree unit, bound to the top level.
// Depends on kmst_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module kmst_checker
  import kmst_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tuser
);
  `CHK_ALWAYS(a_last_user, clk, rst_n, out_tlast == out_tuser, "tlast and tuser differ")
  `CHK_ALWAYS(a_no_both, clk, rst_n, !(in_tready && out_tvalid), "input taken while result pending")
  `CHK_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `CHK_ALWAYS(a_edge_nocost, clk, rst_n, !(out_tvalid && !out_tlast) || out_tdata[47:26] == 22'd0, "cost on edge item")
endmodule
bind kruskal_minimum_spanning_tree_unit kmst_checker u_chk (.*);
`default_nettype wire
